FILE: design/opwt_pkg.sv
`default_nettype none

package opwt_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 24;

   // register indexes on the csr port
   localparam logic [2:0] CSR_CONTROL_OFFSET = 3'd0;
   localparam logic [2:0] CSR_UNIT_SPACING   = 3'd1;
   localparam logic [2:0] CSR_WHEEL_RADIUS   = 3'd2;
   localparam logic [2:0] CSR_TREAD_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_NEAR_WINDOW    = 3'd4;
   localparam logic [2:0] CSR_STOP_WINDOW    = 3'd5;

   localparam logic [19:0] RST_CONTROL_OFFSET = 20'd10486;
   localparam logic [19:0] RST_UNIT_SPACING   = 20'd37356;
   localparam logic [16:0] RST_NEAR_WINDOW    = 17'd3277;
   localparam logic [16:0] RST_STOP_WINDOW    = 17'd655;

   // multiply micro-ops, issued in this order
   localparam logic [3:0] OP_WZ = 4'd0;
   localparam logic [3:0] OP_XY = 4'd1;
   localparam logic [3:0] OP_WW = 4'd2;
   localparam logic [3:0] OP_XX = 4'd3;
   localparam logic [3:0] OP_YY = 4'd4;
   localparam logic [3:0] OP_ZZ = 4'd5;
   localparam logic [3:0] OP_PX = 4'd6;
   localparam logic [3:0] OP_PY = 4'd7;
   localparam logic [3:0] OP_VX = 4'd8;
   localparam logic [3:0] OP_VY = 4'd9;
   localparam logic [3:0] OP_LA = 4'd10;
   localparam logic [3:0] OP_LB = 4'd11;
   localparam logic [3:0] OP_AA = 4'd12;
   localparam logic [3:0] OP_AB = 4'd13;

   localparam logic signed [35:0] ANG_PI      = 36'sd1686629713;
   localparam logic signed [35:0] ANG_HALF_PI = 36'sd843314856;
   localparam logic signed [43:0] CORDIC_K    = 44'sd652032874;
   localparam logic signed [43:0] NORM_LIM    = 44'sd1099511627776;
   localparam logic signed [65:0] HALF_Q30    = 66'sd536870912;
   localparam logic signed [65:0] SAT_MAX     = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN     = -66'sd2147483648;

   localparam logic [29:0] ATAN_TAB [32] = '{
      30'd421657428, 30'd248918915, 30'd131521918, 30'd66762579, 30'd33510843,
      30'd16771758, 30'd8387925, 30'd4194219, 30'd2097141, 30'd1048575,
      30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768, 30'd16384,
      30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128,
      30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0, 30'd0
   };

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > SAT_MAX) begin
         return 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // q2.30 product back to integer scale, rounded half up
   function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
      return (v + HALF_Q30) >>> 30;
   endfunction

endpackage

`default_nettype wire

FILE: design/offset_point_waypoint_tracker_unit.sv
// pose beat: quaternion products, yaw atan2 and cos/sin, control point, error windows, error
// atan2 and cos/sin, velocity products and divide; each of the two atan2 passes normalizes with
// up to 40 shifts, an atan2 of the origin skips its normalize and iterate steps, and the divide
// steps are skipped when the angular divide saturates or the offset is zero. target beat: no result.
// one item at a time; the shared multiplier, cordic shifter and restoring divider set the rate.
// synchronous active-high reset restores register defaults and clears goal and final latch.
`default_nettype none

module offset_point_waypoint_tracker_unit
   import opwt_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, tgt_x, tgt_y,
   // tgt_index, tgt_speed
   input  wire logic [239:0]  req_tdata,
   input  wire logic          req_tuser,   // action
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   // linear_velocity, angular_velocity, reach_x, reach_y, reach_index,
   // final_reached, zero pad
   output      logic [151:0]  rsp_tdata,
   output      logic          rsp_tuser,   // reach_valid
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [19:0]   csr_data
);

   localparam int IW = $clog2(CORDIC_ITERATIONS);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_MUL  = 11'b00000000010,
      ST_VPRE = 11'b00000000100,
      ST_NORM = 11'b00000001000,
      ST_VIT  = 11'b00000010000,
      ST_RPRE = 11'b00000100000,
      ST_RIT  = 11'b00001000000,
      ST_ERR  = 11'b00010000000,
      ST_DPRE = 11'b00100000000,
      ST_DIV  = 11'b01000000000,
      ST_DONE = 11'b10000000000
   } state_type;

   typedef struct packed {
      logic near_x;
      logic near_y;
      logic stop_x;
      logic stop_y;
   } win_type;

   state_type state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic ph_ff, ph_in, pass_ff, pass_in;

   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;
   logic signed [31:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [31:0] goal_speed_ff, goal_speed_in;
   logic [15:0] goal_index_ff, goal_index_in;
   logic final_ff, final_in;

   logic [19:0] off_ff, off_in, sp_ff, sp_in;
   logic [16:0] near_ff, near_in, stop_ff, stop_in;

   logic signed [43:0] x_ff, x_in, y_ff, y_in;
   logic signed [35:0] z_ff, z_in;
   logic neg_ff, neg_in;
   logic [IW-1:0] it_ff, it_in;

   logic signed [32:0] cyaw_ff, cyaw_in, syaw_ff, syaw_in, ct_ff, ct_in, st_ff, st_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [32:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [65:0] p_ff, p_in, acc_ff, acc_in;
   logic signed [31:0] lin_ff, lin_in, angv_ff, angv_in;
   win_type win_ff, win_in;

   logic [33:0] r_ff, r_in;
   logic [31:0] dq_ff, dq_in;
   logic [4:0] dcnt_ff, dcnt_in;
   logic dneg_ff, dneg_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic [151:0] rsp_data_ff, rsp_data_in;

   // shared datapath
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [43:0] x_sh, y_sh, x_nx, y_nx;
   logic signed [35:0] atan_v;
   logic it_last;
   logic signed [33:0] dx, dy, nwv, swv;
   logic signed [65:0] mag;
   logic [33:0] den;
   logic [34:0] r2;
   logic ge;
   logic rep, fin;
   logic [31:0] q;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      case (op_ff)
         OP_WZ:   begin mul_a = 33'(qw_ff);   mul_b = 33'(qz_ff);   end
         OP_XY:   begin mul_a = 33'(qx_ff);   mul_b = 33'(qy_ff);   end
         OP_WW:   begin mul_a = 33'(qw_ff);   mul_b = 33'(qw_ff);   end
         OP_XX:   begin mul_a = 33'(qx_ff);   mul_b = 33'(qx_ff);   end
         OP_YY:   begin mul_a = 33'(qy_ff);   mul_b = 33'(qy_ff);   end
         OP_ZZ:   begin mul_a = 33'(qz_ff);   mul_b = 33'(qz_ff);   end
         OP_PX:   begin mul_a = $signed({13'b0, off_ff}); mul_b = cyaw_ff; end
         OP_PY:   begin mul_a = $signed({13'b0, off_ff}); mul_b = syaw_ff; end
         OP_VX:   begin mul_a = 33'(goal_speed_ff); mul_b = ct_ff; end
         OP_VY:   begin mul_a = 33'(goal_speed_ff); mul_b = st_ff; end
         OP_LA:   begin mul_a = cyaw_ff; mul_b = vx_ff; end
         OP_LB:   begin mul_a = syaw_ff; mul_b = vy_ff; end
         OP_AA:   begin mul_a = syaw_ff; mul_b = vx_ff; end
         OP_AB:   begin mul_a = cyaw_ff; mul_b = vy_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // cordic step, vectoring or rotation chosen by state
   assign x_sh    = x_ff >>> it_ff;
   assign y_sh    = y_ff >>> it_ff;
   assign atan_v  = $signed({6'b0, ATAN_TAB[5'(it_ff)]});
   assign it_last = (it_ff == IW'(CORDIC_ITERATIONS - 1));

   always_comb begin
      if (state_ff == ST_VIT) begin
         x_nx = y_ff[43] ? x_ff - y_sh : x_ff + y_sh;
         y_nx = y_ff[43] ? y_ff + x_sh : y_ff - x_sh;
      end else begin
         x_nx = z_ff[35] ? x_ff + y_sh : x_ff - y_sh;
         y_nx = z_ff[35] ? y_ff - x_sh : y_ff + x_sh;
      end
   end

   assign dx  = 34'(goal_x_ff) - 34'(px_ff);
   assign dy  = 34'(goal_y_ff) - 34'(py_ff);
   assign nwv = $signed({17'b0, near_ff});
   assign swv = $signed({17'b0, stop_ff});

   assign mag = acc_ff[65] ? -acc_ff : acc_ff;
   assign den = {off_ff, 14'b0};
   assign r2  = {r_ff, dq_ff[31]};
   assign ge  = (r2 >= {1'b0, den});
   assign q   = {dq_ff[30:0], ge};

   assign rep = win_ff.near_x && win_ff.near_y && !final_ff;
   assign fin = final_ff || (rep && win_ff.stop_x && win_ff.stop_y);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      ph_in = ph_ff;
      pass_in = pass_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      qz_in = qz_ff;
      qw_in = qw_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      goal_speed_in = goal_speed_ff;
      goal_index_in = goal_index_ff;
      final_in = final_ff;
      off_in = off_ff;
      sp_in = sp_ff;
      near_in = near_ff;
      stop_in = stop_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      neg_in = neg_ff;
      it_in = it_ff;
      cyaw_in = cyaw_ff;
      syaw_in = syaw_ff;
      ct_in = ct_ff;
      st_in = st_ff;
      px_in = px_ff;
      py_in = py_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      p_in = p_ff;
      acc_in = acc_ff;
      lin_in = lin_ff;
      angv_in = angv_ff;
      win_in = win_ff;
      r_in = r_ff;
      dq_in = dq_ff;
      dcnt_in = dcnt_ff;
      dneg_in = dneg_ff;
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // wheel radius and tread width cancel in the wheel mapping, so they are not kept
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONTROL_OFFSET: off_in  = csr_data;
            CSR_UNIT_SPACING:   sp_in   = csr_data;
            CSR_NEAR_WINDOW:    near_in = csr_data[16:0];
            CSR_STOP_WINDOW:    stop_in = csr_data[16:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  goal_x_in     = req_tdata[159:128];
                  goal_y_in     = req_tdata[191:160];
                  goal_index_in = req_tdata[207:192];
                  goal_speed_in = req_tdata[239:208];
                  final_in      = 1'b0;
               end else begin
                  pos_x_in = req_tdata[31:0];
                  pos_y_in = req_tdata[63:32];
                  qx_in    = req_tdata[79:64];
                  qy_in    = req_tdata[95:80];
                  qz_in    = req_tdata[111:96];
                  qw_in    = req_tdata[127:112];
                  op_in    = OP_WZ;
                  ph_in    = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            ph_in = !ph_ff;
            if (!ph_ff) begin
               p_in = mul_p;
            end else begin
               op_in = op_ff + 4'd1;
               case (op_ff)
                  OP_WZ: y_in = p_ff[43:0] <<< 1;
                  OP_XY: y_in = y_ff + (p_ff[43:0] <<< 1);
                  OP_WW: x_in = p_ff[43:0];
                  OP_XX: x_in = x_ff + p_ff[43:0];
                  OP_YY: x_in = x_ff - p_ff[43:0];
                  OP_ZZ: begin
                     x_in     = x_ff - p_ff[43:0];
                     pass_in  = 1'b0;
                     state_in = ST_VPRE;
                  end
                  OP_PX: px_in = sat32(66'(pos_x_ff) + 66'(off_ff) + 66'(sp_ff) - rnd30(p_ff));
                  OP_PY: begin
                     py_in    = sat32(66'(pos_y_ff) - rnd30(p_ff));
                     state_in = ST_ERR;
                  end
                  OP_VX: vx_in = win_ff.stop_x ? '0 : 33'(rnd30(p_ff));
                  OP_VY: vy_in = win_ff.stop_y ? '0 : 33'(rnd30(p_ff));
                  OP_LA: acc_in = p_ff;
                  OP_LB: lin_in = sat32(rnd30(acc_ff + p_ff));
                  OP_AA: acc_in = p_ff;
                  OP_AB: begin
                     acc_in   = acc_ff - p_ff;
                     state_in = ST_DPRE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_VPRE: begin
            z_in = '0;
            if (x_ff == '0 && y_ff == '0) begin
               // atan2 of the origin is taken as zero
               state_in = ST_RPRE;
            end else begin
               if (x_ff[43]) begin
                  z_in = y_ff[43] ? -ANG_PI : ANG_PI;
                  x_in = -x_ff;
                  y_in = -y_ff;
               end
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (x_ff >= NORM_LIM || x_ff <= -NORM_LIM ||
                y_ff >= NORM_LIM || y_ff <= -NORM_LIM) begin
               it_in    = '0;
               state_in = ST_VIT;
            end else begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end
         end
         ST_VIT: begin
            x_in  = x_nx;
            y_in  = y_nx;
            z_in  = y_ff[43] ? z_ff - atan_v : z_ff + atan_v;
            it_in = it_ff + 1'b1;
            if (it_last) begin
               state_in = ST_RPRE;
            end
         end
         ST_RPRE: begin
            neg_in = 1'b0;
            if (z_ff > ANG_HALF_PI) begin
               z_in   = z_ff - ANG_PI;
               neg_in = 1'b1;
            end else if (z_ff < -ANG_HALF_PI) begin
               z_in   = z_ff + ANG_PI;
               neg_in = 1'b1;
            end
            x_in     = CORDIC_K;
            y_in     = '0;
            it_in    = '0;
            state_in = ST_RIT;
         end
         ST_RIT: begin
            x_in  = x_nx;
            y_in  = y_nx;
            z_in  = z_ff[35] ? z_ff + atan_v : z_ff - atan_v;
            it_in = it_ff + 1'b1;
            if (it_last) begin
               if (!pass_ff) begin
                  cyaw_in = neg_ff ? 33'(-x_nx) : 33'(x_nx);
                  syaw_in = neg_ff ? 33'(-y_nx) : 33'(y_nx);
               end else begin
                  ct_in = neg_ff ? 33'(-x_nx) : 33'(x_nx);
                  st_in = neg_ff ? 33'(-y_nx) : 33'(y_nx);
               end
               ph_in    = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_ERR: begin
            win_in.near_x = (dx > -nwv) && (dx < nwv);
            win_in.near_y = (dy > -nwv) && (dy < nwv);
            win_in.stop_x = win_in.near_x && (dx > -swv) && (dx < swv);
            win_in.stop_y = win_in.near_y && (dy > -swv) && (dy < swv);
            x_in     = 44'(dx);
            y_in     = 44'(dy);
            pass_in  = 1'b1;
            state_in = ST_VPRE;
         end
         ST_DPRE: begin
            dneg_in = acc_ff[65];
            r_in    = mag[65:32];
            dq_in   = mag[31:0];
            dcnt_in = '0;
            if (off_ff == '0) begin
               angv_in  = '0;
               state_in = ST_DONE;
            end else if (mag >= $signed({1'b0, den, 31'b0})) begin
               // quotient does not fit, saturate by sign
               angv_in  = acc_ff[65] ? 32'sh80000000 : 32'sh7fffffff;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            r_in    = ge ? 34'(r2 - {1'b0, den}) : r2[33:0];
            dq_in   = q;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               angv_in  = dneg_ff ? -q : q;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               final_in     = fin;
               rsp_valid_in = 1'b1;
               rsp_user_in  = rep;
               rsp_data_in  = {7'b0, fin,
                               rep ? goal_index_ff : 16'd0,
                               rep ? py_ff : 32'sd0,
                               rep ? px_ff : 32'sd0,
                               angv_ff, lin_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_WZ;
         ph_ff         <= 1'b0;
         pass_ff       <= 1'b0;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         goal_speed_ff <= '0;
         goal_index_ff <= '0;
         final_ff      <= 1'b0;
         off_ff        <= RST_CONTROL_OFFSET;
         sp_ff         <= RST_UNIT_SPACING;
         near_ff       <= RST_NEAR_WINDOW;
         stop_ff       <= RST_STOP_WINDOW;
         it_ff         <= '0;
         dcnt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         ph_ff         <= ph_in;
         pass_ff       <= pass_in;
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         goal_speed_ff <= goal_speed_in;
         goal_index_ff <= goal_index_in;
         final_ff      <= final_in;
         off_ff        <= off_in;
         sp_ff         <= sp_in;
         near_ff       <= near_in;
         stop_ff       <= stop_in;
         it_ff         <= it_in;
         dcnt_ff       <= dcnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      qz_ff       <= qz_in;
      qw_ff       <= qw_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      neg_ff      <= neg_in;
      cyaw_ff     <= cyaw_in;
      syaw_ff     <= syaw_in;
      ct_ff       <= ct_in;
      st_ff       <= st_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      p_ff        <= p_in;
      acc_ff      <= acc_in;
      lin_ff      <= lin_in;
      angv_ff     <= angv_in;
      win_ff      <= win_in;
      r_ff        <= r_in;
      dq_ff       <= dq_in;
      dneg_ff     <= dneg_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_pose_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser) |=> !req_tready)
      else $error("input taken while a pose beat is in work");

   a_target_clears: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !final_ff)
      else $error("final latch not cleared by new target");

   a_no_report_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[143:64] == '0))
      else $error("reach fields set without a reach report");

endmodule

`default_nettype wire

FILE: sim/offset_point_waypoint_tracker_unit_checker.sv
`default_nettype none

module offset_point_waypoint_tracker_unit_checker
   import opwt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   input  wire logic [239:0]  req_tdata,
   input  wire logic          req_tuser,
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic [151:0]  rsp_tdata,
   input  wire logic          rsp_tuser,
   input  wire logic          csr_valid,
   input  wire logic          csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [19:0]   csr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 pose_count,
   output int                 reach_count,
   output int                 final_count
);

   typedef struct {
      logic signed [31:0] lin;
      logic signed [31:0] ang;
      logic               reach;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic [15:0]        ridx;
      logic               fin;
   } drive_cmd_type;

   localparam longint HALF = 64'sd536870912;

   drive_cmd_type cmd_queue [$];

   logic [19:0] offset_reg, spacing_reg;
   logic [16:0] near_reg, stop_reg;
   longint      goal_x, goal_y, goal_speed;
   logic [15:0] goal_index;
   logic        final_latch;

   assign pending = cmd_queue.size();

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_q30(longint a, longint b);
      return (a * b + HALF) >>> 30;
   endfunction

   // vectoring cordic, q3.29 radians
   function automatic longint heading(longint y, longint x);
      longint z, nx, ny, m;
      int     i;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
         x = -x;
         y = -y;
      end
      for (i = 0; i < 64; i++) begin
         m = mag(x) > mag(y) ? mag(x) : mag(y);
         if (m >= (64'sd1 <<< 40)) break;
         x = x * 2;
         y = y * 2;
      end
      for (i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += longint'(ATAN_TAB[i & 31]);
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= longint'(ATAN_TAB[i & 31]);
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   task automatic cos_sin(input longint z, output longint c, output longint s);
      longint x, y, nx, ny;
      logic   flip;
      int     i;
      x = longint'(CORDIC_K);
      y = 0;
      flip = 1'b0;
      if (z > longint'(ANG_HALF_PI)) begin
         z -= longint'(ANG_PI);
         flip = 1'b1;
      end else if (z < -longint'(ANG_HALF_PI)) begin
         z += longint'(ANG_PI);
         flip = 1'b1;
      end
      for (i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= longint'(ATAN_TAB[i & 31]);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += longint'(ATAN_TAB[i & 31]);
         end
         x = nx;
         y = ny;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_drive(input logic [239:0] d, output drive_cmd_type r);
      longint qx, qy, qz, qw, yaw, cy, sy, px, py, dx, dy, ct, st;
      longint vx, vy, off, nw, sw;
      logic   nx, ny, sx, sy_stop, rep;
      qx = longint'($signed(d[79:64]));
      qy = longint'($signed(d[95:80]));
      qz = longint'($signed(d[111:96]));
      qw = longint'($signed(d[127:112]));
      yaw = heading(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
      cos_sin(yaw, cy, sy);
      off = longint'(offset_reg);
      px = clamp32(longint'($signed(d[31:0])) + off + longint'(spacing_reg)
                   - round_q30(off, cy));
      py = clamp32(longint'($signed(d[63:32])) - round_q30(off, sy));
      dx = goal_x - px;
      dy = goal_y - py;
      cos_sin(heading(dy, dx), ct, st);
      vx = round_q30(goal_speed, ct);
      vy = round_q30(goal_speed, st);
      nw = longint'(near_reg);
      sw = longint'(stop_reg);
      nx = (dx > -nw) && (dx < nw);
      ny = (dy > -nw) && (dy < nw);
      sx = nx && (dx > -sw) && (dx < sw);
      sy_stop = ny && (dy > -sw) && (dy < sw);
      if (sx) vx = 0;
      if (sy_stop) vy = 0;
      rep = nx && ny && !final_latch;
      if (rep && sx && sy_stop) final_latch = 1'b1;
      r.lin = 32'(clamp32((cy * vx + sy * vy + HALF) >>> 30));
      r.ang = (off != 0) ? 32'(clamp32((sy * vx - cy * vy) / (off <<< 14))) : 32'sd0;
      r.reach = rep;
      r.rx = rep ? 32'(px) : 32'sd0;
      r.ry = rep ? 32'(py) : 32'sd0;
      r.ridx = rep ? goal_index : 16'd0;
      r.fin = final_latch;
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pose_count = 0;
      reach_count = 0;
      final_count = 0;
   end

   always @(posedge clock) begin
      drive_cmd_type e, p;
      if (reset) begin
         offset_reg <= RST_CONTROL_OFFSET;
         spacing_reg <= RST_UNIT_SPACING;
         near_reg <= RST_NEAR_WINDOW;
         stop_reg <= RST_STOP_WINDOW;
         goal_x = 0;
         goal_y = 0;
         goal_speed = 0;
         goal_index = '0;
         final_latch = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CONTROL_OFFSET: offset_reg <= csr_data;
               CSR_UNIT_SPACING:   spacing_reg <= csr_data;
               CSR_NEAR_WINDOW:    near_reg <= csr_data[16:0];
               CSR_STOP_WINDOW:    stop_reg <= csr_data[16:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               goal_x = longint'($signed(req_tdata[159:128]));
               goal_y = longint'($signed(req_tdata[191:160]));
               goal_index = req_tdata[207:192];
               goal_speed = longint'($signed(req_tdata[239:208]));
               final_latch = 1'b0;
            end else begin
               predict_drive(req_tdata, p);
               cmd_queue.push_back(p);
               pose_count++;
               if (p.reach) reach_count++;
               if (p.fin) final_count++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_queue.size() == 0) begin
               $display("mismatch: result beat with nothing expected at %0t", $realtime);
               fail_count++;
            end else begin
               e = cmd_queue.pop_front();
               if (rsp_tdata[31:0] !== e.lin)
                  report("linear_velocity", $signed(rsp_tdata[31:0]), e.lin);
               if (rsp_tdata[63:32] !== e.ang)
                  report("angular_velocity", $signed(rsp_tdata[63:32]), e.ang);
               if (rsp_tuser !== e.reach)
                  report("reach_valid", rsp_tuser, e.reach);
               if (rsp_tdata[95:64] !== e.rx)
                  report("reach_x", $signed(rsp_tdata[95:64]), e.rx);
               if (rsp_tdata[127:96] !== e.ry)
                  report("reach_y", $signed(rsp_tdata[127:96]), e.ry);
               if (rsp_tdata[143:128] !== e.ridx)
                  report("reach_index", rsp_tdata[143:128], e.ridx);
               if (rsp_tdata[144] !== e.fin)
                  report("final_reached", rsp_tdata[144], e.fin);
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: sim/offset_point_waypoint_tracker_unit_tb.sv
`default_nettype none

module offset_point_waypoint_tracker_unit_tb
   import opwt_pkg::*;
();

   localparam int STALL_LIMIT = 5000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [239:0]  req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [151:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_valid;
   logic          csr_ready;
   logic [2:0]    csr_index;
   logic [19:0]   csr_data;

   int fail_count, pending, pose_count, reach_count, final_count;
   int quiet_cycles;
   logic steady;

   // stimulus-side copies of the registers that shape near-target poses
   longint spacing_now, near_now;

   offset_point_waypoint_tracker_unit dut (.*);

   offset_point_waypoint_tracker_unit_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      rsp_tready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      reset <= 1'b1;
      steady = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog: no beat of any kind for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // result side
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [19:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_UNIT_SPACING) spacing_now = longint'(val);
      if (idx == CSR_NEAR_WINDOW) near_now = longint'(val[16:0]);
   endtask

   task automatic push_beat(input logic act, input logic [239:0] d);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= act;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [15:0] rand_quat();
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   task automatic send_pose(input logic [31:0] px, input logic [31:0] py,
                            input logic [15:0] qx, input logic [15:0] qy,
                            input logic [15:0] qz, input logic [15:0] qw);
      push_beat(1'b0, {$urandom(), 16'($urandom()), $urandom(), $urandom(),
                       qw, qz, qy, qx, py, px});
   endtask

   task automatic send_target(input logic [31:0] tx, input logic [31:0] ty,
                              input logic [15:0] idx, input logic [31:0] spd);
      push_beat(1'b1, {spd, idx, ty, tx, rand_quat(), rand_quat(), rand_quat(),
                       rand_quat(), $urandom(), $urandom()});
   endtask

   // let the block drain, including a possible trailing target beat
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // a target followed by poses whose control point lands around it
   task automatic run_approach(output int cnt);
      longint tx, ty, ex, ey, win;
      int n, k;
      logic [15:0] qz, qw;
      tx = longint'($signed(32'($urandom_range(0, 32'h3fffffff)))) - 64'sd536870912;
      ty = longint'($signed(32'($urandom_range(0, 32'h3fffffff)))) - 64'sd536870912;
      send_target(32'(tx), 32'(ty), 16'($urandom()), $urandom());
      n = $urandom_range(2, 8);
      cnt = n + 1;
      win = 2 * near_now + 2;
      for (k = 0; k < n; k++) begin
         ex = longint'($urandom_range(0, 32'(2 * win))) - win;
         ey = longint'($urandom_range(0, 32'(2 * win))) - win;
         if ($urandom_range(0, 3) == 0) begin
            ex = ex / 8;
            ey = ey / 8;
         end
         qz = 16'd0;
         qw = 16'd16384;
         if ($urandom_range(0, 9) < 3) begin
            qz = rand_quat();
            qw = rand_quat();
         end
         send_pose(32'(tx - spacing_now + ex), 32'(ty + ey), 16'd0, 16'd0, qz, qw);
      end
   endtask

   task automatic run_phase(input int items);
      int sent, got;
      sent = 0;
      while (sent < items) begin
         if ((sent % 64) == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            run_approach(got);
            sent += got;
         end else if ($urandom_range(0, 3) == 0) begin
            send_target($urandom(), $urandom(), 16'($urandom()), $urandom());
            sent++;
         end else begin
            send_pose($urandom(), $urandom(), rand_quat(), rand_quat(), rand_quat(),
                      rand_quat());
            sent++;
         end
      end
      steady = 1'b0;
      settle();
   endtask

   initial begin
      spacing_now = longint'(RST_UNIT_SPACING);
      near_now = longint'(RST_NEAR_WINDOW);
      @(negedge reset);
      @(posedge clock);

      // directed: reset settings
      send_pose(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      send_target(32'd0, 32'd0, 16'hffff, 32'd65536);
      send_pose(-32'sd37356, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      send_pose(-32'sd37356, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      send_target(32'd1000, 32'd0, 16'd7, 32'h80000000);
      send_pose(-32'sd37356, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      send_pose(-32'sd37356, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      // error exactly on and just inside the near window
      send_pose(32'(1000 - 3277 - 37356), 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      send_pose(32'(1000 - 3276 - 37356), 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      send_pose(32'h7fffffff, 32'h7fffffff, 16'd16384, 16'd16384, 16'd16384, 16'd16384);
      send_pose(32'h80000000, 32'h80000000, -16'sd16384, -16'sd16384, -16'sd16384,
                -16'sd16384);
      // zero quaternion gives heading zero
      send_pose(32'd12345, -32'sd999, 16'd0, 16'd0, 16'd0, 16'd0);
      send_target(32'h7fffffff, 32'h80000000, 16'd0, 32'h7fffffff);
      send_pose(32'h80000000, 32'h7fffffff, 16'd0, 16'd0, 16'd16384, 16'd0);
      send_pose(32'd0, 32'd0, 16'd0, 16'd0, 16'd11585, 16'd11585);
      send_pose(32'd0, 32'd0, 16'd0, 16'd0, -16'sd11585, 16'd11585);
      send_target(32'hffffffff, 32'hffffffff, 16'hffff, 32'hffffffff);
      send_pose(32'hffffffff - 32'd37356, 32'hffffffff, 16'd0, 16'd0, 16'd0, 16'd16384);
      send_pose(32'd5, 32'd5, 16'd0, 16'd0, 16'd0, 16'd0);
      settle();
      run_phase(290);

      // smallest settings, windows closed
      csr_write(CSR_CONTROL_OFFSET, 20'd1);
      csr_write(CSR_UNIT_SPACING, 20'd0);
      csr_write(CSR_WHEEL_RADIUS, 20'd1);
      csr_write(CSR_TREAD_WIDTH, 20'd1);
      csr_write(CSR_NEAR_WINDOW, 20'd0);
      csr_write(CSR_STOP_WINDOW, 20'd0);
      run_phase(290);

      // largest settings
      csr_write(CSR_CONTROL_OFFSET, 20'd655360);
      csr_write(CSR_UNIT_SPACING, 20'd655360);
      csr_write(CSR_WHEEL_RADIUS, 20'd65536);
      csr_write(CSR_TREAD_WIDTH, 20'd131072);
      csr_write(CSR_NEAR_WINDOW, 20'd65536);
      csr_write(CSR_STOP_WINDOW, 20'd65536);
      run_phase(290);

      // zero offset, oversized values masked, unused indexes
      csr_write(CSR_CONTROL_OFFSET, 20'd0);
      csr_write(CSR_UNIT_SPACING, 20'hfffff);
      csr_write(CSR_NEAR_WINDOW, 20'hf4e20);
      csr_write(CSR_STOP_WINDOW, 20'he1388);
      csr_write(3'd6, 20'hfffff);
      csr_write(3'd7, 20'h5a5a5);
      run_phase(290);

      // random settings in range
      csr_write(CSR_CONTROL_OFFSET, 20'($urandom_range(1, 65536)));
      csr_write(CSR_UNIT_SPACING, 20'($urandom_range(0, 655360)));
      csr_write(CSR_NEAR_WINDOW, 20'($urandom_range(1000, 65536)));
      csr_write(CSR_STOP_WINDOW, 20'($urandom_range(0, 2000)));
      run_phase(290);

      $display("covered %0d pose beats under five register settings", pose_count);
      $display("%0d reach reports, %0d results with the final flag set",
               reach_count, final_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
